>>> sv/efrf_pkg.sv
// Shared types and constants for the escaped frame receiver filter.
`default_nettype none
package efrf_pkg;

  localparam int MAX_FRAME = 256;
  localparam int BCNT_W    = $clog2(MAX_FRAME + 1);
  localparam int LEN_W     = 9;
  localparam int LEN_MAX   = (1 << LEN_W) - 1;
  localparam int CNT_W     = 16;
  localparam int EV_W      = 3;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [EV_W-1:0] {
    EV_DATA      = 3'd0,
    EV_MINE      = 3'd1,
    EV_TOKEN_OK  = 3'd2,
    EV_TOKEN_BAD = 3'd3,
    EV_OTHER     = 3'd4,
    EV_STRAY     = 3'd5
  } ev_t;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESC       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_SYNC  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_ESC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOK_CTRL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOK_LOW   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TOK_HIGH  = 3'd7;

  typedef struct packed {
    logic [7:0] sync_char;
    logic [7:0] escape_char;
    logic [7:0] raw_sync_char;
    logic [7:0] raw_escape_char;
    logic [7:0] own_address;
    logic [7:0] token_control;
    logic [7:0] token_check_low;
    logic [7:0] token_check_high;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] out_of_frame_count;
    logic [CNT_W-1:0] frames_for_me_count;
    logic [LEN_W-1:0] frame_length;
    logic [7:0]       data_byte;
  } res_t;

endpackage
`default_nettype wire

>>> sv/efrf_cfg_regs.sv
// Configuration register file for the frame receiver filter.
`default_nettype none
module efrf_cfg_regs
  import efrf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [7:0]           wr_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_SYNC:     cfg_nxt.sync_char        = wr_data;
        REG_ESC:      cfg_nxt.escape_char      = wr_data;
        REG_RAW_SYNC: cfg_nxt.raw_sync_char    = wr_data;
        REG_RAW_ESC:  cfg_nxt.raw_escape_char  = wr_data;
        REG_OWN_ADDR: cfg_nxt.own_address      = wr_data;
        REG_TOK_CTRL: cfg_nxt.token_control    = wr_data;
        REG_TOK_LOW:  cfg_nxt.token_check_low  = wr_data;
        REG_TOK_HIGH: cfg_nxt.token_check_high = wr_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_char        <= 8'd126;
      cfg_r.escape_char      <= 8'd125;
      cfg_r.raw_sync_char    <= 8'd94;
      cfg_r.raw_escape_char  <= 8'd93;
      cfg_r.own_address      <= 8'd0;
      cfg_r.token_control    <= 8'd0;
      cfg_r.token_check_low  <= 8'd0;
      cfg_r.token_check_high <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> sv/efrf_core.sv
// Deframing state, frame checks and result register.
`default_nettype none
module efrf_core
  import efrf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output ev_t             out_ev,
  output res_t            out_res
);

  logic              in_frame_r, in_frame_nxt;
  logic              esc_r, esc_nxt;
  logic [BCNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]        hdr_r [4];
  logic [7:0]        hdr_nxt [4];
  logic [CNT_W-1:0]  mine_r, mine_nxt;
  logic [CNT_W-1:0]  stray_r, stray_nxt;
  logic              out_valid_r, out_valid_nxt;
  ev_t               ev_r, ev_nxt;
  res_t              res_r, res_nxt;

  logic              in_fire;
  logic              is_sync;
  logic              res_vld;
  logic [7:0]        dec_byte;
  logic [LEN_W-1:0]  len_sat;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_sync  = (in_byte == cfg.sync_char);
  assign len_sat  = (32'(cnt_r) > 32'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(cnt_r);

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    cnt_nxt      = cnt_r;
    hdr_nxt      = hdr_r;
    mine_nxt     = mine_r;
    stray_nxt    = stray_r;
    res_vld      = 1'b0;
    ev_nxt       = EV_DATA;
    dec_byte     = in_byte;

    if (in_fire) begin
      if (is_sync) begin
        if (cnt_r == '0) begin
          in_frame_nxt = 1'b1;
        end else begin
          in_frame_nxt = 1'b0;
          cnt_nxt      = '0;
          res_vld      = 1'b1;
          if (hdr_r[0] == cfg.own_address) begin
            mine_nxt = mine_r + 1'b1;
            if (hdr_r[1] == cfg.token_control) begin
              ev_nxt = (hdr_r[2] == cfg.token_check_low &&
                        hdr_r[3] == cfg.token_check_high) ? EV_TOKEN_OK : EV_TOKEN_BAD;
            end else begin
              ev_nxt = EV_MINE;
            end
          end else begin
            ev_nxt = EV_OTHER;
          end
        end
      end else if (!in_frame_r) begin
        stray_nxt = stray_r + 1'b1;
        res_vld   = 1'b1;
        ev_nxt    = EV_STRAY;
      end else if (!esc_r && in_byte == cfg.escape_char) begin
        esc_nxt = 1'b1;
      end else begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          if (in_byte == cfg.raw_sync_char) begin
            dec_byte = cfg.sync_char;
          end else if (in_byte == cfg.raw_escape_char) begin
            dec_byte = cfg.escape_char;
          end
        end
        if (32'(cnt_r) < 32'd4) begin
          hdr_nxt[cnt_r[1:0]] = dec_byte;
        end
        if (32'(cnt_r) < 32'(MAX_FRAME)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        res_vld = 1'b1;
        ev_nxt  = EV_DATA;
      end
    end

    res_nxt.data_byte           = (ev_nxt == EV_DATA) ? dec_byte : 8'd0;
    res_nxt.frame_length        = (is_sync) ? len_sat : '0;
    res_nxt.frames_for_me_count = mine_nxt;
    res_nxt.out_of_frame_count  = stray_nxt;

    if (in_fire && res_vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      esc_r       <= 1'b0;
      cnt_r       <= '0;
      hdr_r       <= '{default: 8'd0};
      mine_r      <= '0;
      stray_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      esc_r       <= esc_nxt;
      cnt_r       <= cnt_nxt;
      hdr_r       <= hdr_nxt;
      mine_r      <= mine_nxt;
      stray_r     <= stray_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_vld) begin
      ev_r  <= ev_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ev    = ev_r;
  assign out_res   = res_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(MAX_FRAME))
    else $error("byte count above frame limit");

  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> cnt_r == '0)
    else $error("bytes collected outside a frame");

  a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_vld |=> out_valid_r)
    else $error("result of accepted request not presented");

  a_stray_inc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_frame_r && !is_sync |=> stray_r == CNT_W'($past(stray_r) + 1'b1))
    else $error("out-of-frame counter not advanced");

endmodule
`default_nettype wire

>>> sv/escaped_frame_receiver_filter.sv
// Top level of the escaped frame receiver filter.
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one line byte per cycle; in_tready drops only while a result waits.
// Escape bytes inside a frame and frame-opening syncs are accepted without a result.
// Reset (rst_n low, synchronous) clears framing state, header bytes and counters
// and loads the framing characters with their default values.
`default_nettype none
module escaped_frame_receiver_filter
  import efrf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] rx_byte
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [55:0]               out_tdata,  // [7:0] data_byte, [16:8] frame_length,
                                                // [32:17] frames_for_me_count,
                                                // [48:33] out_of_frame_count, zero above
  output logic [EV_W-1:0]           out_tuser,  // [2:0] event_res
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  cfg_t cfg;
  ev_t  ev;
  res_t res;

  assign cfg_ready = 1'b1;

  efrf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  efrf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ev    (ev),
    .out_res   (res)
  );

  assign out_tdata = {7'd0, res};
  assign out_tuser = ev;

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Testbench for escaped_frame_receiver_filter: random framed traffic checked against a predictor.
`timescale 1ns / 1ps

import efrf_pkg::*;

class frame_tracker;
  cfg_t             regs;
  bit               framing;
  bit               esc_armed;
  int unsigned      collected;
  logic [7:0]       header [4];
  logic [CNT_W-1:0] mine_cnt;
  logic [CNT_W-1:0] stray_cnt;
  ev_t              due_ev [$];
  logic [55:0]      due_word [$];
  int unsigned      errors;

  function new();
    regs.sync_char        = 8'd126;
    regs.escape_char      = 8'd125;
    regs.raw_sync_char    = 8'd94;
    regs.raw_escape_char  = 8'd93;
    regs.own_address      = 8'd0;
    regs.token_control    = 8'd0;
    regs.token_check_low  = 8'd0;
    regs.token_check_high = 8'd0;
    framing   = 1'b0;
    esc_armed = 1'b0;
    collected = 0;
    foreach (header[k]) header[k] = 8'd0;
    mine_cnt  = '0;
    stray_cnt = '0;
    errors    = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    case (idx)
      REG_SYNC:     regs.sync_char        = val;
      REG_ESC:      regs.escape_char      = val;
      REG_RAW_SYNC: regs.raw_sync_char    = val;
      REG_RAW_ESC:  regs.raw_escape_char  = val;
      REG_OWN_ADDR: regs.own_address      = val;
      REG_TOK_CTRL: regs.token_control    = val;
      REG_TOK_LOW:  regs.token_check_low  = val;
      REG_TOK_HIGH: regs.token_check_high = val;
      default: ;
    endcase
  endfunction

  function int unsigned outstanding();
    return due_ev.size();
  endfunction

  function void queue_event(ev_t ev, logic [7:0] db, int unsigned len);
    logic [LEN_W-1:0] len_sat;
    len_sat = (len > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(len);
    due_ev.push_back(ev);
    due_word.push_back({7'd0, stray_cnt, mine_cnt, len_sat, db});
  endfunction

  // accepted line byte request
  function void note_rx_byte(logic [7:0] b);
    logic [7:0] v;
    ev_t        ev;
    v = b;
    if (v == regs.sync_char) begin
      if (collected == 0) begin
        framing = 1'b1;
        return;
      end
      framing = 1'b0;
      if (header[0] == regs.own_address) begin
        mine_cnt = mine_cnt + 1'b1;
        if (header[1] == regs.token_control) begin
          ev = (header[2] == regs.token_check_low && header[3] == regs.token_check_high) ?
               EV_TOKEN_OK : EV_TOKEN_BAD;
        end else begin
          ev = EV_MINE;
        end
      end else begin
        ev = EV_OTHER;
      end
      queue_event(ev, 8'd0, collected);
      collected = 0;
      return;
    end
    if (!framing) begin
      stray_cnt = stray_cnt + 1'b1;
      queue_event(EV_STRAY, 8'd0, 0);
      return;
    end
    if (esc_armed) begin
      if (v == regs.raw_sync_char) begin
        v = regs.sync_char;
      end else if (v == regs.raw_escape_char) begin
        v = regs.escape_char;
      end
      esc_armed = 1'b0;
    end else if (v == regs.escape_char) begin
      esc_armed = 1'b1;
      return;
    end
    if (collected < 4) header[collected] = v;
    if (collected < MAX_FRAME) collected++;
    queue_event(EV_DATA, v, 0);
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_event(logic [EV_W-1:0] ev, logic [55:0] word);
    ev_t         want_ev;
    logic [55:0] want;
    if (due_ev.size() == 0) begin
      $display("%0t: unexpected result, event %0d tdata %h", $time, ev, word);
      errors++;
      return;
    end
    want_ev = due_ev.pop_front();
    want    = due_word.pop_front();
    compare_field("event_res", 16'(want_ev), 16'(ev));
    compare_field("data_byte", 16'(want[7:0]), 16'(word[7:0]));
    compare_field("frame_length", 16'(want[16:8]), 16'(word[16:8]));
    compare_field("frames_for_me_count", want[32:17], word[32:17]);
    compare_field("out_of_frame_count", want[48:33], word[48:33]);
    compare_field("tdata padding", 16'(want[55:49]), 16'(word[55:49]));
  endfunction
endclass

module testbench;
  localparam int RANDOM_ITEMS = 850;
  localparam int PHASE_ITEMS  = 150;
  localparam int LONG_HOLD    = 200;
  localparam logic [7:0] OPENING [25] = '{
    8'h00, 8'hFF, 8'h7D,
    8'h7E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7E,
    8'h7E, 8'h00, 8'h01, 8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'h7D, 8'h33, 8'hFF, 8'h7E,
    8'h7E, 8'h7D, 8'h7E, 8'h5E, 8'h7E
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [55:0]          out_tdata;
  logic [EV_W-1:0]      out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  frame_tracker tracker = new();
  bit           src_paced = 1'b1;
  bit           sink_paced = 1'b1;
  bit           sink_long_hold = 1'b0;
  int unsigned  sent_items = 0;
  logic [7:0]   frame_body [$];

  escaped_frame_receiver_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = src_paced ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_rx_byte(b);
    sent_items++;
  endtask

  // sender stops and waits for every pending result, then lets the block go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic load_settings(input cfg_t s);
    write_reg(REG_SYNC, s.sync_char);
    write_reg(REG_ESC, s.escape_char);
    write_reg(REG_RAW_SYNC, s.raw_sync_char);
    write_reg(REG_RAW_ESC, s.raw_escape_char);
    write_reg(REG_OWN_ADDR, s.own_address);
    write_reg(REG_TOK_CTRL, s.token_control);
    write_reg(REG_TOK_LOW, s.token_check_low);
    write_reg(REG_TOK_HIGH, s.token_check_high);
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t pick_settings(int unsigned phase);
    cfg_t s;
    case (phase)
      0: s = {8'd126, 8'd125, 8'd94, 8'd93, 8'd0, 8'd0, 8'd0, 8'd0};
      1: s = {8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
      2: s = {8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
      default: begin
        s = {$urandom, $urandom};
        if (s.escape_char == s.sync_char) s.escape_char = ~s.sync_char;
      end
    endcase
    return s;
  endfunction

  // decoded frame: address, control, two check bytes, payload; cut to len
  function automatic void build_frame(int unsigned len);
    logic [7:0] special [4];
    special[0] = tracker.regs.sync_char;
    special[1] = tracker.regs.escape_char;
    special[2] = tracker.regs.raw_sync_char;
    special[3] = tracker.regs.raw_escape_char;
    frame_body.delete();
    frame_body.push_back($urandom_range(0, 4) < 3 ? tracker.regs.own_address : 8'($urandom));
    frame_body.push_back($urandom_range(0, 1) ? tracker.regs.token_control : 8'($urandom));
    frame_body.push_back($urandom_range(0, 2) != 0 ? tracker.regs.token_check_low :
                         8'($urandom));
    frame_body.push_back($urandom_range(0, 2) != 0 ? tracker.regs.token_check_high :
                         8'($urandom));
    while (frame_body.size() < len) begin
      frame_body.push_back($urandom_range(0, 3) == 0 ? special[$urandom_range(0, 3)] :
                           8'($urandom));
    end
    while (frame_body.size() > len) void'(frame_body.pop_back());
  endfunction

  task automatic send_frame(input bit closed);
    logic [7:0] d;
    send_byte(tracker.regs.sync_char);
    foreach (frame_body[k]) begin
      d = frame_body[k];
      if (d == tracker.regs.sync_char || d == tracker.regs.escape_char) begin
        send_byte(tracker.regs.escape_char);
        send_byte(d == tracker.regs.sync_char ? tracker.regs.raw_sync_char :
                  tracker.regs.raw_escape_char);
      end else if (d != tracker.regs.raw_sync_char && d != tracker.regs.raw_escape_char &&
                   $urandom_range(0, 15) == 0) begin
        // needless escape: byte passes unchanged
        send_byte(tracker.regs.escape_char);
        send_byte(d);
      end else begin
        send_byte(d);
      end
    end
    if (closed) send_byte(tracker.regs.sync_char);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(8'($urandom));
  endtask

  initial begin : result_sink
    int unsigned hold;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = sink_paced ? $urandom_range(0, 14) : 0;
      if (sink_long_hold) begin
        hold = LONG_HOLD;
        sink_long_hold = 1'b0;
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      tracker.check_event(out_tuser, out_tdata);
    end
  end

  initial begin : stimulus
    int unsigned mark;
    int unsigned phase;
    int unsigned frame_no;
    int unsigned kind;
    bit          held;
    bit          paused;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SYNC;
    cfg_data  <= 8'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset framing characters: strays, token frame, escapes, escape across sync
    for (int k = 0; k < 25; k++) send_byte(OPENING[k]);

    settle();
    load_settings(pick_settings(0));
    phase    = 1;
    frame_no = 0;
    held     = 1'b0;
    paused   = 1'b0;
    mark     = sent_items;
    while (sent_items - mark < RANDOM_ITEMS) begin
      if (sent_items - mark >= phase * PHASE_ITEMS) begin
        settle();
        load_settings(pick_settings(phase));
        phase++;
      end
      src_paced  = $urandom_range(0, 3) != 0;
      sink_paced = $urandom_range(0, 3) != 0;
      if (!held && sent_items - mark >= 200) begin
        sink_long_hold = 1'b1;
        src_paced      = 1'b0;
        held           = 1'b1;
      end
      if (!paused && sent_items - mark >= 420) begin
        settle();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        send_noise($urandom_range(0, 2));
        build_frame(frame_no == 10 ? $urandom_range(MAX_FRAME + 1, MAX_FRAME + 6) :
                    $urandom_range(1, 12));
        send_frame(1'b1);
        frame_no++;
      end else if (kind < 16) begin
        send_noise($urandom_range(1, 6));
      end else if (kind == 16) begin
        // escape left pending over a repeated opening sync
        send_byte(tracker.regs.sync_char);
        send_byte(tracker.regs.escape_char);
        build_frame($urandom_range(1, 6));
        send_frame(1'b1);
      end else if (kind < 19) begin
        // frame cut short; the next opening sync closes it
        build_frame($urandom_range(1, 8));
        send_frame(1'b0);
        if ($urandom_range(0, 1)) send_byte(tracker.regs.escape_char);
      end else begin
        send_byte(tracker.regs.sync_char);
        send_noise($urandom_range(1, 8));
        send_byte(tracker.regs.sync_char);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
